// ----- design/tkcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tkcsm_pkg: shared types and constants of the top-k / causal score mask
// configuration register codes, field widths and the per-cell slot control
// ----------------------------------------------------------------------------
package tkcsm_pkg;

    // width of the position, count and length registers
    localparam int POS_BITS   = 7;
    // width of the score and result fields
    localparam int DATA_BITS  = 32;
    // width of the configuration register index
    localparam int INDEX_BITS = 3;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] CFG_KEEP_COUNT = 3'd0;
    localparam logic [INDEX_BITS-1:0] CFG_ROW_LENGTH = 3'd1;
    localparam logic [INDEX_BITS-1:0] CFG_QUERY_ROWS = 3'd2;
    localparam logic [INDEX_BITS-1:0] CFG_MASK_VALUE = 3'd3;

    // control part of a score travelling down the cell row
    typedef struct packed {
        logic                valid;
        logic [POS_BITS-1:0] col;    // column where the score settles
        logic [POS_BITS-1:0] tally;  // earlier scores found greater so far
    } slot_ctl_t;

endpackage

// ----- design/tkcsm_cell.sv -----
// ----------------------------------------------------------------------------
// tkcsm_cell: one column cell of the decode score row
// holds one settled score and its greater-count, compares it with the score
// passing through, and shifts toward cell 0 while a row is emitted
// ----------------------------------------------------------------------------
module tkcsm_cell
    import tkcsm_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int SCORE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         flush,
    input  slot_ctl_t                    slot_ctl_in,
    input  logic signed [SCORE_BITS-1:0] slot_score_in,
    output slot_ctl_t                    slot_ctl_out,
    output logic signed [SCORE_BITS-1:0] slot_score_out,
    input  logic                         shift_en,
    input  logic signed [SCORE_BITS-1:0] shift_score_in,
    input  logic [POS_BITS-1:0]          shift_tally_in,
    output logic signed [SCORE_BITS-1:0] held_score,
    output logic [POS_BITS-1:0]          held_tally
);

    slot_ctl_t                    slot_ctl_reg;
    logic signed [SCORE_BITS-1:0] slot_score_reg;
    logic signed [SCORE_BITS-1:0] held_score_reg;
    logic [POS_BITS-1:0]          held_tally_reg;

    logic land;
    logic new_greater;
    logic new_less;

    assign land        = slot_ctl_reg.valid && (slot_ctl_reg.col == POS_BITS'(IDX));
    assign new_greater = slot_score_reg > held_score_reg;
    assign new_less    = slot_score_reg < held_score_reg;

    // passing score picks up one count for each greater settled score
    always_comb
    begin
        slot_ctl_out.valid = slot_ctl_reg.valid && !land;
        slot_ctl_out.col   = slot_ctl_reg.col;
        slot_ctl_out.tally = slot_ctl_reg.tally + (new_less ? POS_BITS'(1) : POS_BITS'(0));
        slot_score_out     = slot_score_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_ctl_reg <= '0;
        end
        else if (flush)
        begin
            slot_ctl_reg <= '0;
        end
        else
        begin
            slot_ctl_reg <= slot_ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_score_reg <= slot_score_in;
        if (shift_en)
        begin
            held_score_reg <= shift_score_in;
            held_tally_reg <= shift_tally_in;
        end
        else if (land)
        begin
            held_score_reg <= slot_score_reg;
            held_tally_reg <= slot_ctl_reg.tally;
        end
        else if (slot_ctl_reg.valid && new_greater)
        begin
            held_tally_reg <= held_tally_reg + POS_BITS'(1);
        end
    end

    assign held_score = held_score_reg;
    assign held_tally = held_tally_reg;

endmodule

// ----- design/topk_causal_score_mask.sv -----
// prefill (query_rows above 1): one beat accepted per cycle while the output register is free,
//   result registered and shown in the following cycle
// decode (query_rows 0 or 1): a row of L scores takes L input beats, then a drain while the
//   last score walks the cell row to its column, then L result beats; the next row is taken
//   once the last result of the row sits in the output register
// reset: registers return to keep 0, length 64, rows 1, mask -2^31; row and column restart
// ----------------------------------------------------------------------------
// topk_causal_score_mask: row-wise top-k or causal mask for attention scores
// decode rows are ranked in a systolic row of compare cells, prefill rows are
// masked on the fly against the causal limit
// ----------------------------------------------------------------------------
module topk_causal_score_mask
    import tkcsm_pkg::*;
#(
    parameter int MAX_ROW    = 64,
    parameter int SCORE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // score stream
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_BITS-1:0]  score,
    // result stream
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_BITS-1:0]  masked_score,
    output logic                         row_end,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [INDEX_BITS-1:0]        cfg_index,
    input  logic [DATA_BITS-1:0]         cfg_data
);

    // sequencer codes
    localparam logic [1:0] ST_FILL  = 2'd0;  // taking scores
    localparam logic [1:0] ST_DRAIN = 2'd1;  // last decode score still travelling
    localparam logic [1:0] ST_EMIT  = 2'd2;  // shifting the ranked row out

    // configuration registers
    logic [POS_BITS-1:0]         keep_count_reg;
    logic [POS_BITS-1:0]         row_length_reg;
    logic [POS_BITS-1:0]         query_rows_reg;
    logic signed [DATA_BITS-1:0] mask_value_reg;

    // position and sequencing
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] row_reg, row_next;
    logic [1:0]          state_reg, state_next;
    logic [POS_BITS-1:0] drain_cnt_reg, drain_cnt_next;
    logic [POS_BITS-1:0] emit_cnt_reg, emit_cnt_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic signed [DATA_BITS-1:0] masked_score_reg, masked_score_next;
    logic                        row_end_reg, row_end_next;

    logic                        cfg_hit;
    logic                        in_beat;
    logic                        decode;
    logic [POS_BITS-1:0]         len;
    logic                        col_last;
    logic                        causal_masked;
    logic                        pass_all;
    logic                        keep_head;
    logic                        out_free;
    logic                        emit_go;
    logic signed [DATA_BITS-1:0] score_wide;
    logic signed [DATA_BITS-1:0] head_wide;

    // cell row wiring
    slot_ctl_t                    cell_ctl_in   [MAX_ROW];
    logic signed [SCORE_BITS-1:0] cell_score_in [MAX_ROW];
    slot_ctl_t                    cell_ctl_out  [MAX_ROW];
    logic signed [SCORE_BITS-1:0] cell_score_out[MAX_ROW];
    logic signed [SCORE_BITS-1:0] shift_score   [MAX_ROW];
    logic [POS_BITS-1:0]          shift_tally   [MAX_ROW];
    logic signed [SCORE_BITS-1:0] held_score    [MAX_ROW];
    logic [POS_BITS-1:0]          held_tally    [MAX_ROW];

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_KEEP_COUNT ||
                                     cfg_index == CFG_ROW_LENGTH ||
                                     cfg_index == CFG_QUERY_ROWS ||
                                     cfg_index == CFG_MASK_VALUE);

    // top-k in decode, causal mask once a head holds several query rows
    assign decode = query_rows_reg <= POS_BITS'(1);

    // length in use: zero acts as one, clamp at the cell count
    always_comb
    begin
        if (row_length_reg == '0)
        begin
            len = POS_BITS'(1);
        end
        else if (row_length_reg > POS_BITS'(MAX_ROW))
        begin
            len = POS_BITS'(MAX_ROW);
        end
        else
        begin
            len = row_length_reg;
        end
    end

    assign col_last = (8'(col_reg) + 8'd1) >= 8'(len);

    // column masked when col >= len - rows + row + 1, rearranged to stay unsigned
    assign causal_masked = (8'(col_reg) + 8'(query_rows_reg)) >= (8'(len) + 8'(row_reg) + 8'd1);

    assign pass_all  = (keep_count_reg == '0) || (keep_count_reg >= len);
    assign keep_head = pass_all || (held_tally[0] < keep_count_reg);

    assign score_wide = DATA_BITS'(signed'(score[SCORE_BITS-1:0]));
    assign head_wide  = DATA_BITS'(held_score[0]);

    // output register frees up this cycle when empty or being taken
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_FILL) && (decode || out_free);
    assign in_beat  = in_valid && in_ready;
    assign emit_go  = (state_reg == ST_EMIT) && out_free;

    // ------------------------------------------------------------------
    // row of compare cells: a new decode score enters cell 0 and moves one
    // cell per cycle until it reaches its own column
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_ctl_in[0].valid = in_beat && decode;
        cell_ctl_in[0].col   = col_reg;
        cell_ctl_in[0].tally = '0;
        cell_score_in[0]     = score[SCORE_BITS-1:0];
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ROW; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign cell_ctl_in[gi]   = cell_ctl_out[gi-1];
                assign cell_score_in[gi] = cell_score_out[gi-1];
            end
            // emit shifts the settled row toward cell 0
            if (gi < MAX_ROW - 1)
            begin : g_shift
                assign shift_score[gi] = held_score[gi+1];
                assign shift_tally[gi] = held_tally[gi+1];
            end
            else
            begin : g_shift_end
                assign shift_score[gi] = '0;
                assign shift_tally[gi] = '0;
            end

            tkcsm_cell #(
                .IDX        (gi),
                .SCORE_BITS (SCORE_BITS)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .flush          (cfg_hit),
                .slot_ctl_in    (cell_ctl_in[gi]),
                .slot_score_in  (cell_score_in[gi]),
                .slot_ctl_out   (cell_ctl_out[gi]),
                .slot_score_out (cell_score_out[gi]),
                .shift_en       (emit_go),
                .shift_score_in (shift_score[gi]),
                .shift_tally_in (shift_tally[gi]),
                .held_score     (held_score[gi]),
                .held_tally     (held_tally[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // sequencer and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        col_next          = col_reg;
        row_next          = row_reg;
        state_next        = state_reg;
        drain_cnt_next    = drain_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        out_valid_next    = out_valid_reg;
        masked_score_next = masked_score_reg;
        row_end_next      = row_end_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL:
            begin
                if (in_beat)
                begin
                    if (decode)
                    begin
                        // buffer the score; a full row starts the drain
                        if (col_last)
                        begin
                            col_next       = '0;
                            row_next       = '0;
                            drain_cnt_next = len - POS_BITS'(1);
                            state_next     = ST_DRAIN;
                        end
                        else
                        begin
                            col_next = col_reg + POS_BITS'(1);
                        end
                    end
                    else
                    begin
                        // prefill beat goes straight to the output register
                        out_valid_next    = 1'b1;
                        masked_score_next = causal_masked ? mask_value_reg : score_wide;
                        row_end_next      = col_last;
                        if (col_last)
                        begin
                            col_next = '0;
                            if ((8'(row_reg) + 8'd1) >= 8'(query_rows_reg))
                            begin
                                row_next = '0;
                            end
                            else
                            begin
                                row_next = row_reg + POS_BITS'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + POS_BITS'(1);
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // wait for the last score to settle in its cell
                if (drain_cnt_reg == '0)
                begin
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    drain_cnt_next = drain_cnt_reg - POS_BITS'(1);
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next    = 1'b1;
                    masked_score_next = keep_head ? head_wide : mask_value_reg;
                    row_end_next      = (8'(emit_cnt_reg) + 8'd1) >= 8'(len);
                    if ((8'(emit_cnt_reg) + 8'd1) >= 8'(len))
                    begin
                        emit_cnt_next = '0;
                        state_next    = ST_FILL;
                    end
                    else
                    begin
                        emit_cnt_next = emit_cnt_reg + POS_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase

        // a register write restarts the stream and drops a partial row
        if (cfg_hit)
        begin
            col_next       = '0;
            row_next       = '0;
            drain_cnt_next = '0;
            emit_cnt_next  = '0;
            state_next     = ST_FILL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= '0;
            row_length_reg <= POS_BITS'(64);
            query_rows_reg <= POS_BITS'(1);
            mask_value_reg <= {1'b1, {(DATA_BITS-1){1'b0}}};
            col_reg        <= '0;
            row_reg        <= '0;
            state_reg      <= ST_FILL;
            drain_cnt_reg  <= '0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            state_reg     <= state_next;
            drain_cnt_reg <= drain_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_KEEP_COUNT: keep_count_reg <= cfg_data[POS_BITS-1:0];
                    CFG_ROW_LENGTH: row_length_reg <= cfg_data[POS_BITS-1:0];
                    CFG_QUERY_ROWS: query_rows_reg <= cfg_data[POS_BITS-1:0];
                    CFG_MASK_VALUE: mask_value_reg <= signed'(cfg_data);
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        masked_score_reg <= masked_score_next;
        row_end_reg      <= row_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign masked_score = masked_score_reg;
    assign row_end      = row_end_reg;

`ifndef ASSERT_OFF
    // a travelling score always settles before running off the cell row
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_ctl_out[MAX_ROW-1].valid)
        else $error("decode score ran past the last cell");

    // scores are only taken while the row is filling
    a_ready_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_FILL))
        else $error("input ready outside fill");

    // emit count stays inside the row
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emit_cnt_reg < len))
        else $error("emit count beyond row length");

    // drain and emit only happen in decode
    a_decode_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FILL) |-> decode)
        else $error("decode sequencing in prefill mode");

    // a finished drain hands over to emit
    a_drain_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && (drain_cnt_reg == '0) && !cfg_hit)
        |=> (state_reg == ST_EMIT))
        else $error("drain did not move to emit");
`endif

endmodule
